// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the upscaler.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clock, reset_n, cond, expr, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clock, reset_n, cond, expr, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/bun_pkg.sv =====
// ---------------------------------------------------------------------------
// bun_pkg
// Constants, types and the divider step function of the bilinear upscaler.
// ---------------------------------------------------------------------------
package bun_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_SCALE  = 16;

    localparam int COORD_W = 12;
    localparam int PIX_W   = 8;
    localparam int RND_W   = 15;

    localparam int WREG_W     = 9;
    localparam int HREG_W     = 9;
    localparam int SREG_W     = 5;
    localparam int NREG_W     = 7;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_RANGE = 2'd3;

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_HEIGHT);
    localparam int BANK_AW = (CW - 1) + (RW - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int NBANK   = 4;

    localparam int WGT_W = 2 * SREG_W;
    localparam int NUM_W = PIX_W + WGT_W + 2;
    localparam int NZ_W  = NREG_W + 1;

    localparam int DIV_NW     = NUM_W;
    localparam int DIV_DW     = WGT_W;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = (DIV_NW + DIV_STEPS - 1) / DIV_STEPS;

    localparam int ST_A     = DIV_STAGES + 1;
    localparam int ST_M     = ST_A + 1;
    localparam int ST_O     = ST_M + DIV_STAGES + 1;
    localparam int N_STAGES = ST_O + 1;

    typedef struct packed {
        logic [DIV_DW-1:0] rem;
        logic [DIV_NW-1:0] dq;
    } div_t;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pv;
        logic [RND_W-1:0]   rnd;
    } in_t;

    typedef struct packed {
        logic             kind;
        logic             load_ok;
        logic [PIX_W-1:0] pv;
        logic [CW-1:0]    lx;
        logic [RW-1:0]    ly;
    } side_t;

    typedef struct packed {
        logic             smp;
        logic             ix0;
        logic             iy0;
        logic             xcl;
        logic             ycl;
        logic [WGT_W-1:0] w00;
        logic [WGT_W-1:0] w10;
        logic [WGT_W-1:0] w01;
        logic [WGT_W-1:0] w11;
        logic [NZ_W-1:0]  nz;
    } a_t;

    function automatic div_t div_step(input div_t s, input logic [DIV_DW-1:0] den);
        logic [DIV_DW:0] t;
        logic            qb;
        div_t            r;
        t  = {s.rem, s.dq[DIV_NW-1]};
        qb = 1'b0;
        if (t >= {1'b0, den})
        begin
            t  = t - {1'b0, den};
            qb = 1'b1;
        end
        r.rem = t[DIV_DW-1:0];
        r.dq  = {s.dq[DIV_NW-2:0], qb};
        return r;
    endfunction

endpackage

// ===== rtl/bun_ram.sv =====
// ---------------------------------------------------------------------------
// bun_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bun_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bun_div.sv =====
// ---------------------------------------------------------------------------
// bun_div
// Pipelined restoring divider, a few quotient bits per stage.
// ---------------------------------------------------------------------------
module bun_div (
    input  logic                             clk,
    input  logic [bun_pkg::DIV_STAGES-1:0]   en,
    input  logic [bun_pkg::DIV_NW-1:0]       num,
    input  logic [bun_pkg::DIV_DW-1:0]       den,
    output logic [bun_pkg::DIV_NW-1:0]       quot,
    output logic [bun_pkg::DIV_DW-1:0]       rem
);

    bun_pkg::div_t             st_reg   [bun_pkg::DIV_STAGES];
    bun_pkg::div_t             st_next  [bun_pkg::DIV_STAGES];
    logic [bun_pkg::DIV_DW-1:0] den_reg  [bun_pkg::DIV_STAGES];
    logic [bun_pkg::DIV_DW-1:0] den_next [bun_pkg::DIV_STAGES];

    always_comb
    begin
        bun_pkg::div_t             cur;
        logic [bun_pkg::DIV_DW-1:0] d;
        for (int k = 0; k < bun_pkg::DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                cur.rem = '0;
                cur.dq  = num;
                d       = den;
            end
            else
            begin
                cur = st_reg[k-1];
                d   = den_reg[k-1];
            end
            for (int j = 0; j < bun_pkg::DIV_STEPS; j++)
            begin
                if (k * bun_pkg::DIV_STEPS + j < bun_pkg::DIV_NW)
                begin
                    cur = bun_pkg::div_step(cur, d);
                end
            end
            st_next[k]  = cur;
            den_next[k] = d;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < bun_pkg::DIV_STAGES; k++)
        begin
            if (en[k])
            begin
                st_reg[k]  <= st_next[k];
                den_reg[k] <= den_next[k];
            end
        end
    end

    assign quot = st_reg[bun_pkg::DIV_STAGES-1].dq;
    assign rem  = st_reg[bun_pkg::DIV_STAGES-1].rem;

endmodule

// ===== rtl/bilinear_upscaler_with_noise.sv =====
// ---------------------------------------------------------------------------
// bilinear_upscaler_with_noise
// Source field store with bilinear upscaling and additive noise.
// ---------------------------------------------------------------------------
// The block takes one item per cycle while in_stall is low and returns the
// result of each sample in input order; loads give no result. The pipeline
// runs through the coordinate split and noise dividers, the registered read
// of the four source banks and the blend normalization divider. The banks
// are split by row and column parity so that all four neighbors are read in
// the same cycle. The store has no reset and needs no clearing pass; only
// written pixels may be sampled.
module bilinear_upscaler_with_noise (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [bun_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bun_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [bun_pkg::COORD_W-1:0]       x_coord,
    input  logic [bun_pkg::COORD_W-1:0]       y_coord,
    input  logic [bun_pkg::PIX_W-1:0]         pixel_value,
    input  logic [bun_pkg::RND_W-1:0]         random_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bun_pkg::PIX_W-1:0]         pixel_out
);

    logic [bun_pkg::WREG_W-1:0] src_width_reg;
    logic [bun_pkg::HREG_W-1:0] src_height_reg;
    logic [bun_pkg::SREG_W-1:0] scale_reg;
    logic [bun_pkg::NREG_W-1:0] noise_range_reg;

    logic [bun_pkg::WREG_W-1:0] w_eff;
    logic [bun_pkg::HREG_W-1:0] h_eff;
    logic [bun_pkg::SREG_W-1:0] s_eff;
    logic [bun_pkg::WREG_W+bun_pkg::SREG_W-1:0] x_last;
    logic [bun_pkg::HREG_W+bun_pkg::SREG_W-1:0] y_last;
    logic [bun_pkg::DIV_DW-1:0] ss;

    logic [bun_pkg::N_STAGES-1:0] v_reg;
    logic [bun_pkg::N_STAGES-1:0] v_next;
    logic [bun_pkg::N_STAGES:0]   en;

    bun_pkg::in_t   in_reg;
    bun_pkg::side_t side0;
    bun_pkg::side_t side_reg [1:bun_pkg::DIV_STAGES];
    logic [bun_pkg::COORD_W-1:0] xv;
    logic [bun_pkg::COORD_W-1:0] yv;

    logic [bun_pkg::DIV_NW-1:0] xq;
    logic [bun_pkg::DIV_NW-1:0] yq;
    logic [bun_pkg::DIV_DW-1:0] xr;
    logic [bun_pkg::DIV_DW-1:0] yr;
    logic [bun_pkg::DIV_DW-1:0] nr;

    logic [bun_pkg::CW-1:0]     ix;
    logic [bun_pkg::CW-1:0]     ix_p1;
    logic [bun_pkg::RW-1:0]     iy;
    logic [bun_pkg::RW-1:0]     iy_p1;
    logic [bun_pkg::SREG_W-1:0] gx;
    logic [bun_pkg::SREG_W-1:0] gy;
    logic [bun_pkg::SREG_W-1:0] fx;
    logic [bun_pkg::SREG_W-1:0] fy;
    bun_pkg::a_t a_next;
    bun_pkg::a_t a_reg;

    logic                        bank_we    [bun_pkg::NBANK];
    logic [bun_pkg::BANK_AW-1:0] bank_waddr;
    logic [bun_pkg::BANK_AW-1:0] bank_raddr [bun_pkg::NBANK];
    logic [bun_pkg::PIX_W-1:0]   bank_rdata [bun_pkg::NBANK];

    logic [bun_pkg::PIX_W-1:0] p00;
    logic [bun_pkg::PIX_W-1:0] p10;
    logic [bun_pkg::PIX_W-1:0] p01;
    logic [bun_pkg::PIX_W-1:0] p11;
    logic [bun_pkg::NUM_W-1:0] num_next;
    logic [bun_pkg::NUM_W-1:0] num_reg;
    logic [bun_pkg::NZ_W-1:0]  m_nz_reg;
    logic [bun_pkg::NZ_W-1:0]  nz_reg [1:bun_pkg::DIV_STAGES];

    logic [bun_pkg::DIV_NW-1:0] bq;
    logic [bun_pkg::DIV_DW-1:0] br;
    logic signed [bun_pkg::PIX_W+2:0] val;
    logic [bun_pkg::PIX_W-1:0] pix_next;
    logic [bun_pkg::PIX_W-1:0] pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= bun_pkg::WREG_W'(256);
            src_height_reg  <= bun_pkg::HREG_W'(256);
            scale_reg       <= bun_pkg::SREG_W'(1);
            noise_range_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bun_pkg::REG_SRC_WIDTH:   src_width_reg   <= cfg_data[bun_pkg::WREG_W-1:0];
                bun_pkg::REG_SRC_HEIGHT:  src_height_reg  <= cfg_data[bun_pkg::HREG_W-1:0];
                bun_pkg::REG_SCALE:       scale_reg       <= cfg_data[bun_pkg::SREG_W-1:0];
                bun_pkg::REG_NOISE_RANGE: noise_range_reg <= cfg_data[bun_pkg::NREG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (src_width_reg == '0)
            w_eff = bun_pkg::WREG_W'(1);
        else if (src_width_reg > bun_pkg::WREG_W'(bun_pkg::MAX_WIDTH))
            w_eff = bun_pkg::WREG_W'(bun_pkg::MAX_WIDTH);
        else
            w_eff = src_width_reg;
        if (src_height_reg == '0)
            h_eff = bun_pkg::HREG_W'(1);
        else if (src_height_reg > bun_pkg::HREG_W'(bun_pkg::MAX_HEIGHT))
            h_eff = bun_pkg::HREG_W'(bun_pkg::MAX_HEIGHT);
        else
            h_eff = src_height_reg;
        if (scale_reg == '0)
            s_eff = bun_pkg::SREG_W'(1);
        else if (scale_reg > bun_pkg::SREG_W'(bun_pkg::MAX_SCALE))
            s_eff = bun_pkg::SREG_W'(bun_pkg::MAX_SCALE);
        else
            s_eff = scale_reg;
        x_last = (bun_pkg::WREG_W+bun_pkg::SREG_W)'(w_eff) * s_eff
               - (bun_pkg::WREG_W+bun_pkg::SREG_W)'(1);
        y_last = (bun_pkg::HREG_W+bun_pkg::SREG_W)'(h_eff) * s_eff
               - (bun_pkg::HREG_W+bun_pkg::SREG_W)'(1);
        ss = bun_pkg::DIV_DW'(s_eff) * bun_pkg::DIV_DW'(s_eff);
    end

    always_comb
    begin
        en[bun_pkg::N_STAGES] = !out_stall;
        for (int k = bun_pkg::N_STAGES - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < bun_pkg::N_STAGES; k++)
        begin
            v_next[k] = v_reg[k];
            if (en[k])
            begin
                if (k == 0)
                    v_next[k] = in_valid;
                else if (k == bun_pkg::ST_M)
                    v_next[k] = v_reg[bun_pkg::ST_A] && a_reg.smp;
                else
                    v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[bun_pkg::ST_O];
    assign pixel_out = pix_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            in_reg.kind <= kind;
            in_reg.x    <= x_coord;
            in_reg.y    <= y_coord;
            in_reg.pv   <= pixel_value;
            in_reg.rnd  <= random_word;
        end
    end

    always_comb
    begin
        if (in_reg.kind && ((bun_pkg::WREG_W+bun_pkg::SREG_W)'(in_reg.x) > x_last))
            xv = x_last[bun_pkg::COORD_W-1:0];
        else
            xv = in_reg.x;
        if (in_reg.kind && ((bun_pkg::HREG_W+bun_pkg::SREG_W)'(in_reg.y) > y_last))
            yv = y_last[bun_pkg::COORD_W-1:0];
        else
            yv = in_reg.y;
        side0.kind    = in_reg.kind;
        side0.load_ok = (in_reg.x < bun_pkg::COORD_W'(w_eff))
                     && (in_reg.y < bun_pkg::COORD_W'(h_eff));
        side0.pv      = in_reg.pv;
        side0.lx      = in_reg.x[bun_pkg::CW-1:0];
        side0.ly      = in_reg.y[bun_pkg::RW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            side_reg[1] <= side0;
        for (int k = 2; k <= bun_pkg::DIV_STAGES; k++)
        begin
            if (en[k])
                side_reg[k] <= side_reg[k-1];
        end
    end

    bun_div u_div_x (
        .clk  (clk),
        .en   (en[bun_pkg::DIV_STAGES:1]),
        .num  (bun_pkg::DIV_NW'(xv)),
        .den  (bun_pkg::DIV_DW'(s_eff)),
        .quot (xq),
        .rem  (xr)
    );

    bun_div u_div_y (
        .clk  (clk),
        .en   (en[bun_pkg::DIV_STAGES:1]),
        .num  (bun_pkg::DIV_NW'(yv)),
        .den  (bun_pkg::DIV_DW'(s_eff)),
        .quot (yq),
        .rem  (yr)
    );

    bun_div u_div_noise (
        .clk  (clk),
        .en   (en[bun_pkg::DIV_STAGES:1]),
        .num  (bun_pkg::DIV_NW'(in_reg.rnd)),
        .den  (bun_pkg::DIV_DW'({noise_range_reg, 1'b0})),
        .quot (),
        .rem  (nr)
    );

    always_comb
    begin
        bun_pkg::side_t sd;
        sd    = side_reg[bun_pkg::DIV_STAGES];
        ix    = xq[bun_pkg::CW-1:0];
        iy    = yq[bun_pkg::RW-1:0];
        ix_p1 = bun_pkg::CW'(ix + bun_pkg::CW'(1));
        iy_p1 = bun_pkg::RW'(iy + bun_pkg::RW'(1));
        fx    = xr[bun_pkg::SREG_W-1:0];
        fy    = yr[bun_pkg::SREG_W-1:0];
        gx    = s_eff - fx;
        gy    = s_eff - fy;
        a_next.smp = sd.kind;
        a_next.ix0 = ix[0];
        a_next.iy0 = iy[0];
        a_next.xcl = bun_pkg::WREG_W'(ix) == bun_pkg::WREG_W'(w_eff - bun_pkg::WREG_W'(1));
        a_next.ycl = bun_pkg::HREG_W'(iy) == bun_pkg::HREG_W'(h_eff - bun_pkg::HREG_W'(1));
        a_next.w00 = bun_pkg::WGT_W'(gx) * bun_pkg::WGT_W'(gy);
        a_next.w10 = bun_pkg::WGT_W'(fx) * bun_pkg::WGT_W'(gy);
        a_next.w01 = bun_pkg::WGT_W'(gx) * bun_pkg::WGT_W'(fy);
        a_next.w11 = bun_pkg::WGT_W'(fx) * bun_pkg::WGT_W'(fy);
        a_next.nz  = nr[bun_pkg::NZ_W-1:0];
        bank_waddr = {sd.ly[bun_pkg::RW-1:1], sd.lx[bun_pkg::CW-1:1]};
        for (int b = 0; b < bun_pkg::NBANK; b++)
        begin
            logic [bun_pkg::CW-1:0] col;
            logic [bun_pkg::RW-1:0] row;
            col = (ix[0] == b[0]) ? ix : ix_p1;
            row = (iy[0] == b[1]) ? iy : iy_p1;
            bank_raddr[b] = {row[bun_pkg::RW-1:1], col[bun_pkg::CW-1:1]};
            bank_we[b]    = en[bun_pkg::ST_A] && v_reg[bun_pkg::DIV_STAGES] && !sd.kind
                         && sd.load_ok && (sd.lx[0] == b[0]) && (sd.ly[0] == b[1]);
        end
    end

    for (genvar g = 0; g < bun_pkg::NBANK; g++)
    begin : g_bank
        bun_ram #(
            .WIDTH (bun_pkg::PIX_W),
            .DEPTH (bun_pkg::BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[g]),
            .waddr (bank_waddr),
            .wdata (side_reg[bun_pkg::DIV_STAGES].pv),
            .re    (en[bun_pkg::ST_A]),
            .raddr (bank_raddr[g]),
            .rdata (bank_rdata[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en[bun_pkg::ST_A])
            a_reg <= a_next;
    end

    always_comb
    begin
        p00 = bank_rdata[{a_reg.iy0, a_reg.ix0}];
        p10 = a_reg.xcl ? p00 : bank_rdata[{a_reg.iy0, ~a_reg.ix0}];
        p01 = a_reg.ycl ? p00 : bank_rdata[{~a_reg.iy0, a_reg.ix0}];
        if (a_reg.xcl)
            p11 = p01;
        else if (a_reg.ycl)
            p11 = p10;
        else
            p11 = bank_rdata[{~a_reg.iy0, ~a_reg.ix0}];
        num_next = bun_pkg::NUM_W'(p00) * bun_pkg::NUM_W'(a_reg.w00)
                 + bun_pkg::NUM_W'(p10) * bun_pkg::NUM_W'(a_reg.w10)
                 + bun_pkg::NUM_W'(p01) * bun_pkg::NUM_W'(a_reg.w01)
                 + bun_pkg::NUM_W'(p11) * bun_pkg::NUM_W'(a_reg.w11);
    end

    always_ff @(posedge clk)
    begin
        if (en[bun_pkg::ST_M])
        begin
            num_reg  <= num_next;
            m_nz_reg <= a_reg.nz;
        end
        if (en[bun_pkg::ST_M+1])
            nz_reg[1] <= m_nz_reg;
        for (int k = 2; k <= bun_pkg::DIV_STAGES; k++)
        begin
            if (en[bun_pkg::ST_M+k])
                nz_reg[k] <= nz_reg[k-1];
        end
    end

    bun_div u_div_blend (
        .clk  (clk),
        .en   (en[bun_pkg::ST_M+bun_pkg::DIV_STAGES:bun_pkg::ST_M+1]),
        .num  (bun_pkg::DIV_NW'(num_reg)),
        .den  (ss),
        .quot (bq),
        .rem  (br)
    );

    always_comb
    begin
        val = $signed({3'b000, bq[bun_pkg::PIX_W-1:0]});
        if (noise_range_reg != '0)
        begin
            val = val + $signed({3'b000, nz_reg[bun_pkg::DIV_STAGES]})
                      - $signed({4'b0000, noise_range_reg});
        end
        if (val < 0)
            pix_next = '0;
        else if (val > 255)
            pix_next = 8'd255;
        else
            pix_next = val[bun_pkg::PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[bun_pkg::ST_O])
            pix_reg <= pix_next;
    end

`include "assert_macros.svh"

    `ASSERT_IMPLY(a_no_stall_free, clk, rst_n, !out_stall, !in_stall, "input stalled with free output")
    `ASSERT_NEXT(a_load_dropped, clk, rst_n, v_reg[bun_pkg::ST_A] && !a_reg.smp && en[bun_pkg::ST_M], !v_reg[bun_pkg::ST_M], "load reached blend stage")
    `ASSERT_IMPLY(a_col_in_field, clk, rst_n, v_reg[bun_pkg::DIV_STAGES] && side_reg[bun_pkg::DIV_STAGES].kind, (xq < bun_pkg::DIV_NW'(w_eff)) && (yq < bun_pkg::DIV_NW'(h_eff)), "sample index outside field")
    `ASSERT_IMPLY(a_blend_rem, clk, rst_n, v_reg[bun_pkg::ST_O-1], br < ss, "blend remainder not below divisor")

endmodule

// ===== dv/bilinear_upscaler_with_noise_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bilinear_upscaler_with_noise_tb
// Self-checking bench for the bilinear upscaler. Each phase writes the
// registers while the block is idle, fills the whole effective source field
// with load transfers, and then issues sample transfers. A local copy of the
// source field and the registers predicts every output pixel, which is
// compared in order against the output transfers. The sender works in random
// bursts, and the receiver stalls on its own pattern, with one long hold-off.
// ---------------------------------------------------------------------------
module bilinear_upscaler_with_noise_tb;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;
    localparam int   DRAIN_CYCLES = 20;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   HOLDOFF_CYCLES = 400;

    typedef struct {
        logic                        kind;
        logic [bun_pkg::COORD_W-1:0] x;
        logic [bun_pkg::COORD_W-1:0] y;
        logic [bun_pkg::PIX_W-1:0]   pv;
        logic [bun_pkg::RND_W-1:0]   rnd;
    } pixel_op_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [bun_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bun_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           kind = 1'b0;
    logic [bun_pkg::COORD_W-1:0]    x_coord = '0;
    logic [bun_pkg::COORD_W-1:0]    y_coord = '0;
    logic [bun_pkg::PIX_W-1:0]      pixel_value = '0;
    logic [bun_pkg::RND_W-1:0]      random_word = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [bun_pkg::PIX_W-1:0]      pixel_out;

    bilinear_upscaler_with_noise dut (.*);

    pixel_op_t                 op_q[$];
    logic [bun_pkg::PIX_W-1:0] pixel_q[$];
    logic [bun_pkg::PIX_W-1:0] field_mem [0:bun_pkg::MAX_WIDTH*bun_pkg::MAX_HEIGHT-1];
    logic [bun_pkg::WREG_W-1:0] width_reg = 9'd256;
    logic [bun_pkg::HREG_W-1:0] height_reg = 9'd256;
    logic [bun_pkg::SREG_W-1:0] scale_reg = 5'd1;
    logic [bun_pkg::NREG_W-1:0] noise_reg = 7'd0;

    int errors = 0;
    int cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int clamp_reg(input int v, input int hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int field_w();
        return clamp_reg(width_reg, bun_pkg::MAX_WIDTH);
    endfunction

    function automatic int field_h();
        return clamp_reg(height_reg, bun_pkg::MAX_HEIGHT);
    endfunction

    function automatic int field_s();
        return clamp_reg(scale_reg, bun_pkg::MAX_SCALE);
    endfunction

    function automatic logic [bun_pkg::PIX_W-1:0] interp_pixel(input int xc, input int yc,
                                                                 input int rnd);
        int w, h, s, ix, iy, fx, fy, x1, y1, num, d, v;
        w = field_w();
        h = field_h();
        s = field_s();
        if (xc > w * s - 1)
            xc = w * s - 1;
        if (yc > h * s - 1)
            yc = h * s - 1;
        ix = xc / s;
        fx = xc % s;
        iy = yc / s;
        fy = yc % s;
        x1 = (ix == w - 1) ? ix : ix + 1;
        y1 = (iy == h - 1) ? iy : iy + 1;
        num = field_mem[iy * bun_pkg::MAX_WIDTH + ix] * (s - fx) * (s - fy)
            + field_mem[iy * bun_pkg::MAX_WIDTH + x1] * fx * (s - fy)
            + field_mem[y1 * bun_pkg::MAX_WIDTH + ix] * (s - fx) * fy
            + field_mem[y1 * bun_pkg::MAX_WIDTH + x1] * fx * fy;
        d = (noise_reg == 0) ? 0 : (rnd % (2 * noise_reg)) - noise_reg;
        v = num / (s * s) + d;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[bun_pkg::PIX_W-1:0];
    endfunction

    task automatic track_transfer();
        if (kind == KIND_LOAD)
        begin
            if (x_coord < field_w() && y_coord < field_h())
                field_mem[y_coord * bun_pkg::MAX_WIDTH + x_coord] = pixel_value;
        end
        else
            pixel_q.push_back(interp_pixel(x_coord, y_coord, random_word));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            pixel_op_t op;
            if (in_valid && !in_stall)
                track_transfer();
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (op_q.size() > 0)
                begin
                    op = op_q.pop_front();
                    in_valid    <= 1'b1;
                    kind        <= op.kind;
                    x_coord     <= op.x;
                    y_coord     <= op.y;
                    pixel_value <= op.pv;
                    random_word <= op.rnd;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (hold_go && !hold_done)
            begin
                out_stall <= 1'b1;
                if (hold_left >= HOLDOFF_CYCLES)
                    hold_done <= 1'b1;
                hold_left <= hold_left + 1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode <= $urandom_range(0, 3);
                    mode_left  <= $urandom_range(10, 80);
                end
                else
                    mode_left <= mode_left - 1;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pixel_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output transfer: pixel_out=%0d", pixel_out);
            end
            else
            begin
                logic [bun_pkg::PIX_W-1:0] want;
                want = pixel_q.pop_front();
                if (pixel_out !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("pixel_out mismatch: expected %0d, got %0d", want, pixel_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bilinear_upscaler_with_noise_tb: FAIL");
            $finish;
        end
    end

    task automatic push_op(input logic k, input int x, input int y, input int pv,
                           input int rnd);
        pixel_op_t op;
        op.kind = k;
        op.x    = bun_pkg::COORD_W'(x);
        op.y    = bun_pkg::COORD_W'(y);
        op.pv   = bun_pkg::PIX_W'(pv);
        op.rnd  = bun_pkg::RND_W'(rnd);
        op_q.push_back(op);
    endtask

    task automatic wait_idle();
        while (op_q.size() != 0 || in_valid || pixel_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bun_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= bun_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            bun_pkg::REG_SRC_WIDTH:  width_reg  = bun_pkg::WREG_W'(value);
            bun_pkg::REG_SRC_HEIGHT: height_reg = bun_pkg::HREG_W'(value);
            bun_pkg::REG_SCALE:      scale_reg  = bun_pkg::SREG_W'(value);
            default:                 noise_reg  = bun_pkg::NREG_W'(value);
        endcase
    endtask

    // Registers are written, then the full effective field is loaded so that
    // every sample reads only written pixels.
    task automatic start_phase(input int wr, input int hr, input int sr, input int nr);
        wait_idle();
        write_reg(bun_pkg::REG_SRC_WIDTH, wr);
        write_reg(bun_pkg::REG_SRC_HEIGHT, hr);
        write_reg(bun_pkg::REG_SCALE, sr);
        write_reg(bun_pkg::REG_NOISE_RANGE, nr);
        @(posedge clk);
        for (int r = 0; r < field_h(); r++)
            for (int c = 0; c < field_w(); c++)
                push_op(KIND_LOAD, c, r, $urandom_range(0, 255), $urandom_range(0, 32767));
        push_op(KIND_LOAD, field_w(), 0, $urandom_range(0, 255), 0);
        push_op(KIND_LOAD, 0, field_h(), $urandom_range(0, 255), 0);
        push_op(KIND_LOAD, 4095, 4095, 255, 32767);
    endtask

    task automatic random_samples(input int count);
        int xs, ys;
        for (int i = 0; i < count; i++)
        begin
            xs = field_w() * field_s() - 1;
            ys = field_h() * field_s() - 1;
            push_op(KIND_SAMPLE,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, xs),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, ys),
                    $urandom_range(0, 255), $urandom_range(0, 32767));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        start_phase(4, 3, 4, 0);
        push_op(KIND_SAMPLE, 0, 0, 0, 0);
        push_op(KIND_SAMPLE, 15, 11, 0, 32767);
        push_op(KIND_SAMPLE, 4095, 4095, 255, 0);
        push_op(KIND_SAMPLE, 4095, 0, 0, 0);
        push_op(KIND_SAMPLE, 0, 4095, 0, 0);
        push_op(KIND_SAMPLE, 6, 5, 0, 0);
        start_phase(0, 0, 0, 127);
        push_op(KIND_SAMPLE, 0, 0, 0, 0);
        push_op(KIND_SAMPLE, 4095, 4095, 0, 32767);
        push_op(KIND_SAMPLE, 1, 1, 0, 126);
        start_phase(511, 1, 31, 127);
        push_op(KIND_SAMPLE, 4095, 31, 0, 253);
        push_op(KIND_SAMPLE, 4080, 0, 0, 127);
        random_samples(60);
        start_phase(1, 300, 16, 1);
        random_samples(60);

        for (int p = 0; p < 7; p++)
        begin
            start_phase($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 16),
                        ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 127));
            if (p == 2)
                hold_go = 1'b1;
            random_samples(30);
        end

        wait_idle();
        if (errors == 0)
            $display("bilinear_upscaler_with_noise_tb: PASS");
        else
            $display("bilinear_upscaler_with_noise_tb: FAIL");
        $finish;
    end

endmodule
